// ===== sv/vall_pkg.sv =====
// Shared constants, types and helpers for the voice allocator.
`default_nettype none
package vall_pkg;

   localparam int VOICES  = 8;
   localparam int VOICE_W = $clog2(VOICES);
   localparam int NOTE_W  = 7;
   localparam int FUNC_W  = 2;

   localparam logic [FUNC_W-1:0] FUNC_ON    = FUNC_W'(0);
   localparam logic [FUNC_W-1:0] FUNC_OFF   = FUNC_W'(1);
   localparam logic [FUNC_W-1:0] FUNC_RESET = FUNC_W'(2);

   typedef logic [VOICE_W-1:0] voice_type;
   typedef logic [NOTE_W-1:0]  note_type;

   localparam voice_type LAST_VOICE = voice_type'(VOICES - 1);

   typedef struct packed {
      voice_type idx;
      logic      set_busy;
      logic      clr_busy;
      note_type  note;
   } slot_cmd_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } slot_stat_type;

   function automatic voice_type next_voice(input voice_type v);
      return (v == LAST_VOICE) ? '0 : voice_type'(v + 1'b1);
   endfunction

endpackage
`default_nettype wire

// ===== sv/vall_slots.sv =====
// Voice slot table with its shared busy and note compare unit.
`default_nettype none
module vall_slots (
   input  wire                    clock,
   input  wire                    reset,
   input  vall_pkg::slot_cmd_type cmd,
   output vall_pkg::slot_stat_type stat
);

   logic [vall_pkg::VOICES-1:0] busy_ff;
   logic [vall_pkg::VOICES-1:0] busy_in;
   vall_pkg::note_type          note_ff [vall_pkg::VOICES];

   always_comb begin
      busy_in = busy_ff;
      if (cmd.set_busy) begin
         busy_in[cmd.idx] = 1'b1;
      end
      if (cmd.clr_busy) begin
         busy_in[cmd.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_busy) begin
         note_ff[cmd.idx] <= cmd.note;
      end
   end

   assign stat.busy = busy_ff[cmd.idx];
   assign stat.hit  = busy_ff[cmd.idx] && (note_ff[cmd.idx] == cmd.note);

endmodule
`default_nettype wire

// ===== sv/voice_allocator_round_robin.sv =====
// Top level of the round-robin voice allocator: sequencer and result register.
//
// Note events enter on the req_ channel (func, note_number) and routed voice
// events leave on the rsp_ channel (voice, is_off, note_out, last). A transfer
// happens on a rising edge where valid is high and stall is low.
// The block takes one event at a time; req_stall is high while an event is
// being worked on. A small sequencer steps one voice per cycle through a single
// busy and note compare unit. A note-on scans for a holding voice, then, if
// none holds the note, for a free voice from the rotating pointer, then loads
// the result register; if no voice is free it gives no result. A note-off
// scans for the holding voice and frees it. A reset event sends VOICES
// note-offs, one per cycle while the output is not stalled, the last one marked
// by rsp_last. Events with no result free the block in the cycle after their
// scan ends. The result register parts the two sides; while rsp_stall is high
// the result holds and the sequencer waits before loading the next one. The
// reset input frees all voices, zeroes the start pointer and empties the result
// register; no results come out of it.
`default_nettype none
module voice_allocator_round_robin (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [vall_pkg::FUNC_W-1:0]   req_func,
   input  wire [vall_pkg::NOTE_W-1:0]   req_note_number,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [vall_pkg::VOICE_W-1:0] rsp_voice,
   output logic                         rsp_is_off,
   output logic [vall_pkg::NOTE_W-1:0]  rsp_note_out,
   output logic                         rsp_last
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MATCH = 5'b00010,
      S_FREE  = 5'b00100,
      S_EMIT  = 5'b01000,
      S_RESET = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   vall_pkg::voice_type idx_ff, idx_in;
   vall_pkg::voice_type cnt_ff, cnt_in;
   vall_pkg::voice_type ptr_ff, ptr_in;
   logic [vall_pkg::FUNC_W-1:0] func_ff, func_in;
   vall_pkg::note_type note_ff, note_in;

   logic                rsp_valid_ff, rsp_valid_in;
   vall_pkg::voice_type rsp_voice_ff, rsp_voice_in;
   logic                rsp_is_off_ff, rsp_is_off_in;
   vall_pkg::note_type  rsp_note_ff, rsp_note_in;
   logic                rsp_last_ff, rsp_last_in;

   vall_pkg::slot_cmd_type  cmd;
   vall_pkg::slot_stat_type stat;
   logic out_free;
   logic load_rsp;

   vall_slots u_slots (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      func_in       = func_ff;
      note_in       = note_ff;
      load_rsp      = 1'b0;
      rsp_voice_in  = rsp_voice_ff;
      rsp_is_off_in = rsp_is_off_ff;
      rsp_note_in   = rsp_note_ff;
      rsp_last_in   = rsp_last_ff;
      cmd.idx       = idx_ff;
      cmd.set_busy  = 1'b0;
      cmd.clr_busy  = 1'b0;
      cmd.note      = note_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               note_in = req_note_number;
               idx_in  = '0;
               cnt_in  = '0;
               unique case (req_func)
                  vall_pkg::FUNC_ON:    state_in = S_MATCH;
                  vall_pkg::FUNC_OFF:   state_in = S_MATCH;
                  vall_pkg::FUNC_RESET: state_in = S_RESET;
                  default:              state_in = S_IDLE;
               endcase
            end
         end
         S_MATCH: begin
            if (stat.hit) begin
               cmd.clr_busy = (func_ff == vall_pkg::FUNC_OFF);
               state_in     = S_EMIT;
            end else if (idx_ff == vall_pkg::LAST_VOICE) begin
               if (func_ff == vall_pkg::FUNC_ON) begin
                  state_in = S_FREE;
                  idx_in   = ptr_ff;
                  cnt_in   = '0;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               idx_in = vall_pkg::next_voice(idx_ff);
            end
         end
         S_FREE: begin
            if (!stat.busy) begin
               cmd.set_busy = 1'b1;
               ptr_in       = vall_pkg::next_voice(ptr_ff);
               state_in     = S_EMIT;
            end else if (cnt_ff == vall_pkg::LAST_VOICE) begin
               state_in = S_IDLE;
            end else begin
               idx_in = vall_pkg::next_voice(idx_ff);
               cnt_in = vall_pkg::voice_type'(cnt_ff + 1'b1);
            end
         end
         S_EMIT: begin
            if (out_free) begin
               load_rsp      = 1'b1;
               rsp_voice_in  = idx_ff;
               rsp_is_off_in = (func_ff == vall_pkg::FUNC_OFF);
               rsp_note_in   = note_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RESET: begin
            if (out_free) begin
               load_rsp      = 1'b1;
               cmd.clr_busy  = 1'b1;
               rsp_voice_in  = idx_ff;
               rsp_is_off_in = 1'b1;
               rsp_note_in   = note_ff;
               rsp_last_in   = (idx_ff == vall_pkg::LAST_VOICE);
               if (idx_ff == vall_pkg::LAST_VOICE) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = vall_pkg::next_voice(idx_ff);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      func_ff       <= func_in;
      note_ff       <= note_in;
      rsp_voice_ff  <= rsp_voice_in;
      rsp_is_off_ff <= rsp_is_off_in;
      rsp_note_ff   <= rsp_note_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_voice    = rsp_voice_ff;
   assign rsp_is_off   = rsp_is_off_ff;
   assign rsp_note_out = rsp_note_ff;
   assign rsp_last     = rsp_last_ff;

   a_only_reset_unmarked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> rsp_is_off_ff)
      else $error("Unmarked result is not a note-off.");

   a_reset_event_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_func == vall_pkg::FUNC_RESET)
      |=> (state_ff == S_RESET && idx_ff == '0))
      else $error("Reset event did not start its note-off sweep at voice zero.");

   a_reset_sweep_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESET && out_free && idx_ff != vall_pkg::LAST_VOICE)
      |=> (state_ff == S_RESET && rsp_valid_ff && !rsp_last_ff))
      else $error("Reset sweep ended early or lost a note-off.");

   a_emit_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free)
      |=> (state_ff == S_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("Single result was not loaded as the last one.");

endmodule
`default_nettype wire

// ===== bench/voice_allocator_round_robin_checker.sv =====
// Checker for the voice allocator: predicts routed voice events and compares every rsp transfer.
module voice_allocator_round_robin_checker
   import vall_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_stall,
   input  wire [FUNC_W-1:0]   req_func,
   input  wire [NOTE_W-1:0]   req_note_number,
   input  wire                rsp_valid,
   input  wire                rsp_stall,
   input  wire [VOICE_W-1:0]  rsp_voice,
   input  wire                rsp_is_off,
   input  wire [NOTE_W-1:0]   rsp_note_out,
   input  wire                rsp_last,
   output int                 mismatch_count,
   output int                 open_events
);

   typedef struct {
      voice_type voice;
      logic      is_off;
      note_type  note;
      logic      last;
   } voice_event_type;

   voice_event_type expected_events[$];
   logic [VOICES-1:0] voice_busy;
   note_type          voice_note[VOICES];
   voice_type         rotate_ptr;
   int                errors = 0;

   function automatic void push_event(input int v, input logic off, input note_type n,
                                      input logic fin);
      voice_event_type ev;
      ev.voice  = voice_type'(v);
      ev.is_off = off;
      ev.note   = n;
      ev.last   = fin;
      expected_events.push_back(ev);
   endfunction

   // Applies one accepted note event to the voice table and queues the voice events it causes.
   function automatic void route_note_event(input logic [FUNC_W-1:0] f, input note_type n);
      int  i;
      int  v;
      bit  found;
      found = 1'b0;
      case (f)
         FUNC_ON: begin
            for (i = 0; i < VOICES; i++) begin
               if (!found && voice_busy[i] && voice_note[i] == n) begin
                  found = 1'b1;
                  push_event(i, 1'b0, n, 1'b1);
               end
            end
            for (i = 0; i < VOICES; i++) begin
               v = (int'(rotate_ptr) + i) % VOICES;
               if (!found && !voice_busy[v]) begin
                  found         = 1'b1;
                  voice_busy[v] = 1'b1;
                  voice_note[v] = n;
                  rotate_ptr    = voice_type'((int'(rotate_ptr) + 1) % VOICES);
                  push_event(v, 1'b0, n, 1'b1);
               end
            end
         end
         FUNC_OFF: begin
            for (i = 0; i < VOICES; i++) begin
               if (!found && voice_busy[i] && voice_note[i] == n) begin
                  found         = 1'b1;
                  voice_busy[i] = 1'b0;
                  push_event(i, 1'b1, n, 1'b1);
               end
            end
         end
         FUNC_RESET: begin
            for (i = 0; i < VOICES; i++) begin
               voice_busy[i] = 1'b0;
               push_event(i, 1'b1, n, i == VOICES - 1);
            end
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      voice_event_type want;
      if (reset) begin
         voice_busy = '0;
         rotate_ptr = '0;
         expected_events.delete();
      end else begin
         if (req_valid && !req_stall) begin
            route_note_event(req_func, req_note_number);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("unexpected rsp transfer: voice %0d is_off %0d note_out %0d last %0d",
                      rsp_voice, rsp_is_off, rsp_note_out, rsp_last);
               errors++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_voice !== want.voice) begin
                  $error("rsp_voice expected %0d actual %0d", want.voice, rsp_voice);
                  errors++;
               end
               if (rsp_is_off !== want.is_off) begin
                  $error("rsp_is_off expected %0d actual %0d", want.is_off, rsp_is_off);
                  errors++;
               end
               if (rsp_note_out !== want.note) begin
                  $error("rsp_note_out expected %0d actual %0d", want.note, rsp_note_out);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last expected %0d actual %0d", want.last, rsp_last);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      open_events    <= expected_events.size();
   end

endmodule

// ===== bench/voice_allocator_round_robin_tb.sv =====
// Top of the voice allocator testbench: clock, reset, note event stimulus, stall pattern and verdict.
module voice_allocator_round_robin_tb;
   import vall_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 230;
   localparam int POOL_SIZE    = 12;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = FUNC_ON;
   logic [NOTE_W-1:0]   req_note_number = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VOICE_W-1:0]  rsp_voice;
   logic                rsp_is_off;
   logic [NOTE_W-1:0]   rsp_note_out;
   logic                rsp_last;
   int                  mismatch_count;
   int                  open_events;
   int                  cycle_count = 0;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = FUNC_W'(3);

   always #2 clock = ~clock;

   voice_allocator_round_robin DUT (.*);

   voice_allocator_round_robin_checker route_check (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL voice_allocator_round_robin");
         $finish;
      end
   end

   // Holds the event on the req channel until it is accepted.
   task automatic send_event(input logic [FUNC_W-1:0] f, input note_type n);
      req_valid       <= 1'b1;
      req_func        <= f;
      req_note_number <= n;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // The receiver switches between no stalls, light, heavy and long stall stretches.
   initial begin
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin
      note_type          note_pool[POOL_SIZE];
      note_type          n;
      logic [FUNC_W-1:0] f;
      int                counted;
      int                burst_left;
      int                pick;
      int                k;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_event(FUNC_ON, 7'd0);
      send_event(FUNC_ON, 7'd127);
      send_event(FUNC_ON, 7'd127);
      send_event(FUNC_OFF, 7'd0);
      send_event(FUNC_OFF, 7'd0);
      for (k = 1; k <= 7; k++) begin
         send_event(FUNC_ON, note_type'(k * 10));
      end
      send_event(FUNC_ON, 7'd99);
      send_event(FUNC_OFF, 7'd30);
      send_event(FUNC_ON, 7'd99);
      send_event(FUNC_UNUSED, 7'd127);
      send_event(FUNC_RESET, 7'd127);
      send_event(FUNC_RESET, 7'd0);
      send_event(FUNC_OFF, 7'd127);
      send_event(FUNC_ON, 7'h55);
      send_event(FUNC_ON, 7'h2A);
      req_valid <= 1'b0;
      @(posedge clock);

      counted    = 0;
      burst_left = $urandom_range(1, 10);
      while (counted < RANDOM_ITEMS) begin
         if (counted % 40 == 0) begin
            for (k = 0; k < POOL_SIZE; k++) begin
               note_pool[k] = note_type'($urandom_range(0, 127));
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            n = note_type'($urandom_range(0, 127));
         end else begin
            n = note_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            f = FUNC_UNUSED;
         end else if (pick < 8) begin
            f = FUNC_RESET;
         end else if (pick < 58) begin
            f = FUNC_ON;
         end else begin
            f = FUNC_OFF;
         end
         send_event(f, n);
         if (f != FUNC_UNUSED) begin
            counted++;
         end
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (open_events != 0) @(posedge clock);
      repeat (2 * VOICES + 4) @(posedge clock);

      if (mismatch_count == 0 && open_events == 0) begin
         $display("PASS voice_allocator_round_robin");
      end else begin
         $display("FAIL voice_allocator_round_robin");
      end
      $finish;
   end

endmodule
